// ===== rtl/core/lfps_pkg.sv =====
// Shared types, register codes, reset values and saturation helper for the
// line-follower PID steering block. No dependencies.
package lfps_pkg;

  localparam int SensorW   = 12;
  localparam int NumSensor = 10;
  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 16;
  localparam int OutW      = 16;

  typedef enum logic [CfgIndexW-1:0] {
    RegBaseSpeed     = 3'd0,
    RegGainP         = 3'd1,
    RegGainD         = 3'd2,
    RegGainI         = 3'd3,
    RegDeadBand      = 3'd4,
    RegReverseThr    = 3'd5,
    RegReverseSpeed  = 3'd6,
    RegIntegralLimit = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [10:0] base_speed;
    logic [15:0]        gain_p;
    logic [15:0]        gain_d;
    logic [15:0]        gain_i;
    logic [9:0]         dead_band;
    logic [14:0]        reverse_threshold;
    logic signed [10:0] reverse_speed;
    logic [14:0]        integral_limit;
  } cfg_t;

  typedef logic [NumSensor-1:0][SensorW-1:0] frame_t;

  localparam cfg_t CfgReset = '{
    base_speed:        11'sd100,
    gain_p:            16'd3072,
    gain_d:            16'd1229,
    gain_i:            16'd20,
    dead_band:         10'd10,
    reverse_threshold: 15'd170,
    reverse_speed:     -11'sd40,
    integral_limit:    15'd10000
  };

  function automatic logic signed [OutW-1:0] sat16(input logic signed [39:0] v);
    logic signed [OutW-1:0] r;
    if (v > 40'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -40'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[OutW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/lfps_cfg.sv =====
// Configuration register file for the line-follower PID steering block.
// Depends on lfps_pkg.
module lfps_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lfps_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [lfps_pkg::CfgDataW-1:0]   cfg_data,
  output lfps_pkg::cfg_t                  cfg
);
  import lfps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CfgReset;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        RegBaseSpeed:     cfg.base_speed        <= $signed(cfg_data[10:0]);
        RegGainP:         cfg.gain_p            <= cfg_data;
        RegGainD:         cfg.gain_d            <= cfg_data;
        RegGainI:         cfg.gain_i            <= cfg_data;
        RegDeadBand:      cfg.dead_band         <= cfg_data[9:0];
        RegReverseThr:    cfg.reverse_threshold <= cfg_data[14:0];
        RegReverseSpeed:  cfg.reverse_speed     <= $signed(cfg_data[10:0]);
        RegIntegralLimit: cfg.integral_limit    <= cfg_data[14:0];
      endcase
    end
  end

endmodule

// ===== rtl/core/lfps_front.sv =====
// Input register, steering error, and the error history and clamped error sum.
// Depends on lfps_pkg.
module lfps_front #(
  parameter int SENSOR_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lfps_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lfps_pkg::frame_t     frame,
  output logic                 err_valid,
  input  logic                 err_stall,
  output logic signed [15:0]   err,
  output logic signed [16:0]   err_delta,
  output logic signed [15:0]   err_sum
);
  import lfps_pkg::*;

  localparam int UsedBits = (SENSOR_BITS < SensorW) ? SENSOR_BITS : SensorW;
  localparam int SumW     = UsedBits + 8;

  logic                                  v0;
  logic [NumSensor-1:0][UsedBits-1:0]    s0;
  logic                                  stall1;
  logic signed [SumW-1:0]                w [NumSensor];
  logic signed [SumW-1:0]                inner, outer, back, green, front, pick, total;
  logic signed [SumW-1:0]                front_mag, back_mag;
  logic signed [15:0]                    e;
  logic signed [15:0]                    previous_error;
  logic signed [15:0]                    error_sum;
  logic signed [15:0]                    error_sum_next;
  logic signed [16:0]                    sum17, lim17;

  assign stall1   = err_valid && err_stall;
  assign in_stall = v0 && stall1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (!in_stall) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      for (int k = 0; k < NumSensor; k++) begin
        s0[k] <= frame[k][UsedBits-1:0];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NumSensor; k++) begin
      w[k] = $signed({{(SumW-UsedBits){1'b0}}, s0[k]});
    end
    inner = SumW'((w[0] - w[1]) * 2);
    outer = SumW'((w[2] - w[3]) * 4);
    back  = w[4] - w[5];
    green = SumW'(((w[6] - w[8]) - (w[7] - w[9])) * 10);
    front = inner + outer;
    front_mag = front[SumW-1] ? -front : front;
    back_mag  = back[SumW-1] ? -back : back;
    pick  = (front_mag > back_mag) ? front : back;
    total = pick + green;
    e     = sat16(40'(total));

    lim17 = $signed({2'b00, cfg.integral_limit});
    sum17 = 17'(error_sum) + 17'(e);
    if (sum17 > lim17) begin
      error_sum_next = lim17[15:0];
    end else if (sum17 < -lim17) begin
      error_sum_next = 16'(-lim17);
    end else begin
      error_sum_next = sum17[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_valid      <= 1'b0;
      previous_error <= '0;
      error_sum      <= '0;
    end else if (!stall1) begin
      err_valid <= v0;
      if (v0) begin
        previous_error <= e;
        error_sum      <= error_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall1 && v0) begin
      err       <= e;
      err_delta <= 17'(e) - 17'(previous_error);
      err_sum   <= error_sum_next;
    end
  end

endmodule

// ===== rtl/core/lfps_pid.sv =====
// PID product stage and Q12 scaling with saturation and deadband.
// Depends on lfps_pkg.
module lfps_pid (
  input  logic                clk,
  input  logic                rst,
  input  lfps_pkg::cfg_t      cfg,
  input  logic                err_valid,
  output logic                err_stall,
  input  logic signed [15:0]  err,
  input  logic signed [16:0]  err_delta,
  input  logic signed [15:0]  err_sum,
  output logic                corr_valid,
  input  logic                corr_stall,
  output logic signed [15:0]  corr
);
  import lfps_pkg::*;

  logic                 prod_valid;
  logic                 prod_stall;
  logic signed [32:0]   prod_p;
  logic signed [33:0]   prod_d;
  logic signed [32:0]   prod_i;
  logic signed [35:0]   acc, biased;
  logic signed [23:0]   quo;
  logic signed [15:0]   corr_sat, corr_next;
  logic signed [16:0]   corr_wide, corr_mag;

  assign prod_stall = corr_valid && corr_stall;
  assign err_stall  = prod_valid && prod_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (!err_stall) begin
      prod_valid <= err_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!err_stall && err_valid) begin
      prod_p <= 33'($signed({1'b0, cfg.gain_p})) * 33'(err);
      prod_d <= 34'($signed({1'b0, cfg.gain_d})) * 34'(err_delta);
      prod_i <= 33'($signed({1'b0, cfg.gain_i})) * 33'(err_sum);
    end
  end

  always_comb begin
    acc       = 36'(prod_p) - 36'(prod_d) + 36'(prod_i);
    biased    = acc + (acc[35] ? 36'sd4095 : 36'sd0);
    quo       = biased[35:12];
    corr_sat  = sat16(40'(quo));
    corr_wide = 17'(corr_sat);
    corr_mag  = corr_wide[16] ? -corr_wide : corr_wide;
    corr_next = ($unsigned(corr_mag) <= {7'd0, cfg.dead_band}) ? 16'sd0 : corr_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corr_valid <= 1'b0;
    end else if (!prod_stall) begin
      corr_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!prod_stall && prod_valid) begin
      corr <= corr_next;
    end
  end

endmodule

// ===== rtl/core/lfps_drive.sv =====
// Base speed selection and saturated motor commands into the result register.
// Depends on lfps_pkg.
module lfps_drive (
  input  logic                clk,
  input  logic                rst,
  input  lfps_pkg::cfg_t      cfg,
  input  logic                corr_valid,
  output logic                corr_stall,
  input  logic signed [15:0]  corr,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  motor_a_speed,
  output logic signed [15:0]  motor_b_speed,
  output logic signed [15:0]  steer_correction
);
  import lfps_pkg::*;

  logic signed [16:0]  corr_wide, corr_mag;
  logic signed [10:0]  speed;
  logic signed [17:0]  sum_a, sum_b;

  assign corr_stall = out_valid && out_stall;

  always_comb begin
    corr_wide = 17'(corr);
    corr_mag  = corr_wide[16] ? -corr_wide : corr_wide;
    speed     = ($unsigned(corr_mag) >= {2'b00, cfg.reverse_threshold}) ?
                cfg.reverse_speed : cfg.base_speed;
    sum_a     = 18'(speed) - 18'(corr);
    sum_b     = 18'(speed) + 18'(corr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!corr_stall) begin
      out_valid <= corr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!corr_stall && corr_valid) begin
      motor_a_speed    <= sat16(40'(sum_a));
      motor_b_speed    <= sat16(40'(sum_b));
      steer_correction <= corr;
    end
  end

endmodule

// ===== rtl/core/line_follow_pid_steering.sv =====
// Top level of the line-follower PID steering block.
// Depends on lfps_pkg, lfps_cfg, lfps_front, lfps_pid and lfps_drive.
//
//   channel  | handshake            | word
//   ---------+----------------------+----------------------------------------
//   input    | in_valid / in_stall  | ten sensor readings, one frame
//   output   | out_valid / out_stall| motor_a_speed, motor_b_speed, correction
//   config   | cfg_write            | cfg_index, cfg_data
//
// A frame is accepted every cycle while in_stall is low.
// There are five register stages: input, error and sums, products,
// correction, and the result register. Each stage holds its word while the
// next one is full and stalled, so empty stages still take new frames.
// Reset clears the valid bits, the stored error and error sum, and loads the
// register defaults.
module line_follow_pid_steering #(
  parameter int SENSOR_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [lfps_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [lfps_pkg::CfgDataW-1:0]    cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lfps_pkg::SensorW-1:0]     white_left,
  input  logic [lfps_pkg::SensorW-1:0]     white_right,
  input  logic [lfps_pkg::SensorW-1:0]     outer_left,
  input  logic [lfps_pkg::SensorW-1:0]     outer_right,
  input  logic [lfps_pkg::SensorW-1:0]     back_left,
  input  logic [lfps_pkg::SensorW-1:0]     back_right,
  input  logic [lfps_pkg::SensorW-1:0]     green_left,
  input  logic [lfps_pkg::SensorW-1:0]     green_right,
  input  logic [lfps_pkg::SensorW-1:0]     red_left,
  input  logic [lfps_pkg::SensorW-1:0]     red_right,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [lfps_pkg::OutW-1:0] motor_a_speed,
  output logic signed [lfps_pkg::OutW-1:0] motor_b_speed,
  output logic signed [lfps_pkg::OutW-1:0] steer_correction
);
  import lfps_pkg::*;

  cfg_t                cfg;
  frame_t              frame;
  logic                err_valid, err_stall;
  logic signed [15:0]  err;
  logic signed [16:0]  err_delta;
  logic signed [15:0]  err_sum;
  logic                corr_valid, corr_stall;
  logic signed [15:0]  corr;

  assign frame[0] = white_left;
  assign frame[1] = white_right;
  assign frame[2] = outer_left;
  assign frame[3] = outer_right;
  assign frame[4] = back_left;
  assign frame[5] = back_right;
  assign frame[6] = green_left;
  assign frame[7] = green_right;
  assign frame[8] = red_left;
  assign frame[9] = red_right;

  lfps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lfps_front #(
    .SENSOR_BITS (SENSOR_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .frame     (frame),
    .err_valid (err_valid),
    .err_stall (err_stall),
    .err       (err),
    .err_delta (err_delta),
    .err_sum   (err_sum)
  );

  lfps_pid u_pid (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .err_valid  (err_valid),
    .err_stall  (err_stall),
    .err        (err),
    .err_delta  (err_delta),
    .err_sum    (err_sum),
    .corr_valid (corr_valid),
    .corr_stall (corr_stall),
    .corr       (corr)
  );

  lfps_drive u_drive (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .corr_valid       (corr_valid),
    .corr_stall       (corr_stall),
    .corr             (corr),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .motor_a_speed    (motor_a_speed),
    .motor_b_speed    (motor_b_speed),
    .steer_correction (steer_correction)
  );

endmodule

// ===== verif/line_follow_pid_steering_check.sv =====
// Checker for the line-follower PID steering block: watches the frame, result
// and register ports, predicts each result word and compares it field by field.
// Depends on lfps_pkg for the register codes and reset values.
module line_follow_pid_steering_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [lfps_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [lfps_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [lfps_pkg::SensorW-1:0]   white_left,
  input  logic [lfps_pkg::SensorW-1:0]   white_right,
  input  logic [lfps_pkg::SensorW-1:0]   outer_left,
  input  logic [lfps_pkg::SensorW-1:0]   outer_right,
  input  logic [lfps_pkg::SensorW-1:0]   back_left,
  input  logic [lfps_pkg::SensorW-1:0]   back_right,
  input  logic [lfps_pkg::SensorW-1:0]   green_left,
  input  logic [lfps_pkg::SensorW-1:0]   green_right,
  input  logic [lfps_pkg::SensorW-1:0]   red_left,
  input  logic [lfps_pkg::SensorW-1:0]   red_right,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [lfps_pkg::OutW-1:0]      motor_a_speed,
  input  logic [lfps_pkg::OutW-1:0]      motor_b_speed,
  input  logic [lfps_pkg::OutW-1:0]      steer_correction,
  output int                             fail_count,
  output int                             pending,
  output int                             words_checked,
  output int                             deadband_hits,
  output int                             reverse_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  import lfps_pkg::*;

  typedef struct packed {
    logic [OutW-1:0] motor_a;
    logic [OutW-1:0] motor_b;
    logic [OutW-1:0] steer;
  } drive_word_t;

  drive_word_t drive_queue[$];

  int base_speed;
  int gain_p;
  int gain_d;
  int gain_i;
  int dead_band;
  int rev_thr;
  int rev_speed;
  int sum_limit;
  int prev_err;
  int err_sum;

  initial begin
    fail_count = 0;
    pending = 0;
    words_checked = 0;
    deadband_hits = 0;
    reverse_hits = 0;
  end

  function automatic int abs_of(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clip16(input longint v);
    if (v > 32767) begin
      return 32767;
    end
    if (v < -32768) begin
      return -32768;
    end
    return int'(v);
  endfunction

  function automatic drive_word_t steer_predict(
    input logic [SensorW-1:0] white_l, white_r, outer_l, outer_r, back_l, back_r,
    input logic [SensorW-1:0] green_l, green_r, red_l, red_r
  );
    int inner, outer, back, green, front, pick, err, delta, sum, corr, speed;
    longint acc;
    drive_word_t w;
    inner = (int'(white_l) - int'(white_r)) * 2;
    outer = (int'(outer_l) - int'(outer_r)) * 4;
    back = int'(back_l) - int'(back_r);
    green = ((int'(green_l) - int'(red_l)) - (int'(green_r) - int'(red_r))) * 10;
    front = inner + outer;
    pick = (abs_of(front) > abs_of(back)) ? front : back;
    err = clip16(longint'(pick) + green);
    delta = err - prev_err;
    prev_err = err;
    sum = err_sum + err;
    if (sum > sum_limit) begin
      sum = sum_limit;
    end
    if (sum < -sum_limit) begin
      sum = -sum_limit;
    end
    err_sum = sum;
    acc = longint'(gain_p) * err - longint'(gain_d) * delta + longint'(gain_i) * sum;
    corr = clip16(acc / 4096);
    if (abs_of(corr) <= dead_band) begin
      if (corr != 0) begin
        deadband_hits++;
      end
      corr = 0;
    end
    if (abs_of(corr) >= rev_thr) begin
      speed = rev_speed;
      reverse_hits++;
    end else begin
      speed = base_speed;
    end
    w.motor_a = OutW'(clip16(longint'(speed) - corr));
    w.motor_b = OutW'(clip16(longint'(speed) + corr));
    w.steer = OutW'(corr);
    return w;
  endfunction

  task automatic check_field(input string name, input logic [OutW-1:0] want,
                             input logic [OutW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    drive_word_t want;
    if (rst) begin
      base_speed = int'($signed(CfgReset.base_speed));
      gain_p = int'(CfgReset.gain_p);
      gain_d = int'(CfgReset.gain_d);
      gain_i = int'(CfgReset.gain_i);
      dead_band = int'(CfgReset.dead_band);
      rev_thr = int'(CfgReset.reverse_threshold);
      rev_speed = int'($signed(CfgReset.reverse_speed));
      sum_limit = int'(CfgReset.integral_limit);
      prev_err = 0;
      err_sum = 0;
      drive_queue.delete();
    end else begin
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          RegBaseSpeed:     base_speed = int'($signed(cfg_data[10:0]));
          RegGainP:         gain_p = int'(cfg_data);
          RegGainD:         gain_d = int'(cfg_data);
          RegGainI:         gain_i = int'(cfg_data);
          RegDeadBand:      dead_band = int'(cfg_data[9:0]);
          RegReverseThr:    rev_thr = int'(cfg_data[14:0]);
          RegReverseSpeed:  rev_speed = int'($signed(cfg_data[10:0]));
          RegIntegralLimit: sum_limit = int'(cfg_data[14:0]);
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (drive_queue.size() == 0) begin
          $error("result word with no frame outstanding: a=%0d b=%0d corr=%0d",
                 $signed(motor_a_speed), $signed(motor_b_speed),
                 $signed(steer_correction));
          fail_count++;
        end else begin
          want = drive_queue.pop_front();
          check_field("motor_a_speed", want.motor_a, motor_a_speed);
          check_field("motor_b_speed", want.motor_b, motor_b_speed);
          check_field("steer_correction", want.steer, steer_correction);
          words_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        drive_queue.push_back(steer_predict(white_left, white_right, outer_left,
                                            outer_right, back_left, back_right,
                                            green_left, green_right, red_left,
                                            red_right));
      end
    end
    pending = drive_queue.size();
  end

endmodule

// ===== verif/line_follow_pid_steering_test.sv =====
// Top of the line-follower PID steering testbench: clock, reset, sensor frames,
// register settings and result stalls, with the verdict at the end.
// Depends on lfps_pkg, line_follow_pid_steering and line_follow_pid_steering_check.
module line_follow_pid_steering_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lfps_pkg::*;

  localparam int ClkPeriod = 8;
  localparam int NumPhases = 8;
  localparam int PhaseFrames = 250;
  localparam int LongHold = 64;

  typedef struct packed {
    logic [SensorW-1:0] white_left;
    logic [SensorW-1:0] white_right;
    logic [SensorW-1:0] outer_left;
    logic [SensorW-1:0] outer_right;
    logic [SensorW-1:0] back_left;
    logic [SensorW-1:0] back_right;
    logic [SensorW-1:0] green_left;
    logic [SensorW-1:0] green_right;
    logic [SensorW-1:0] red_left;
    logic [SensorW-1:0] red_right;
  } sensor_frame_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [SensorW-1:0] white_left;
  logic [SensorW-1:0] white_right;
  logic [SensorW-1:0] outer_left;
  logic [SensorW-1:0] outer_right;
  logic [SensorW-1:0] back_left;
  logic [SensorW-1:0] back_right;
  logic [SensorW-1:0] green_left;
  logic [SensorW-1:0] green_right;
  logic [SensorW-1:0] red_left;
  logic [SensorW-1:0] red_right;
  logic out_valid;
  logic out_stall;
  logic signed [OutW-1:0] motor_a_speed;
  logic signed [OutW-1:0] motor_b_speed;
  logic signed [OutW-1:0] steer_correction;

  int fail_count;
  int pending;
  int words_checked;
  int deadband_hits;
  int reverse_hits;
  int frames_sent;
  bit calm;
  bit hold_req;

  line_follow_pid_steering u_top (.*);

  line_follow_pid_steering_check u_check (.*);

  always #(ClkPeriod / 2) clk = ~clk;

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(0, 3));
  endfunction

  function automatic sensor_frame_t random_frame();
    logic [9:0][SensorW-1:0] raw;
    int mode, centre, spread, k;
    mode = $urandom_range(0, 9);
    centre = $urandom_range(200, 3895);
    spread = $urandom_range(1, 40);
    for (k = 0; k < 10; k++) begin
      if (mode < 5) begin
        raw[k] = SensorW'(centre + int'($urandom_range(0, 2 * spread)) - spread);
      end else if (mode < 8) begin
        raw[k] = SensorW'($urandom);
      end else begin
        raw[k] = $urandom_range(0, 1) ? '1 : '0;
      end
    end
    return sensor_frame_t'(raw);
  endfunction

  function automatic cfg_t pick_setting(input int phase);
    cfg_t c;
    c = CfgReset;
    case (phase)
      0: ;
      1: begin
        c.base_speed = 11'sd1023;
        c.gain_p = 16'hffff;
        c.gain_d = 16'hffff;
        c.gain_i = 16'hffff;
        c.dead_band = 10'd1023;
        c.reverse_threshold = 15'd32767;
        c.reverse_speed = -11'sd1023;
        c.integral_limit = 15'd32767;
      end
      2: begin
        c.base_speed = -11'sd1023;
        c.gain_p = '0;
        c.gain_d = '0;
        c.gain_i = '0;
        c.dead_band = '0;
        c.reverse_threshold = '0;
        c.reverse_speed = 11'sd1023;
        c.integral_limit = '0;
      end
      default: begin
        c.base_speed = 11'(int'($urandom_range(0, 2046)) - 1023);
        c.reverse_speed = 11'(int'($urandom_range(0, 2046)) - 1023);
        c.gain_p = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192));
        c.gain_d = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096));
        c.gain_i = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 512));
        c.dead_band = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40));
        c.reverse_threshold = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                           : 15'($urandom_range(0, 1000));
        c.integral_limit = 15'($urandom);
      end
    endcase
    return c;
  endfunction

  task automatic load_reg(input reg_index_t idx, input logic [CfgDataW-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
  endtask

  // Unused upper data bits carry random junk, which the block must ignore.
  task automatic set_config(input cfg_t c);
    load_reg(RegBaseSpeed, {5'($urandom), c.base_speed});
    load_reg(RegGainP, c.gain_p);
    load_reg(RegGainD, c.gain_d);
    load_reg(RegGainI, c.gain_i);
    load_reg(RegDeadBand, {6'($urandom), c.dead_band});
    load_reg(RegReverseThr, {1'($urandom), c.reverse_threshold});
    load_reg(RegReverseSpeed, {5'($urandom), c.reverse_speed});
    load_reg(RegIntegralLimit, {1'($urandom), c.integral_limit});
    cfg_write <= 1'b0;
  endtask

  task automatic send_frame(input sensor_frame_t f, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    white_left <= f.white_left;
    white_right <= f.white_right;
    outer_left <= f.outer_left;
    outer_right <= f.outer_right;
    back_left <= f.back_left;
    back_right <= f.back_right;
    green_left <= f.green_left;
    green_right <= f.green_right;
    red_left <= f.red_left;
    red_right <= f.red_right;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frames_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : sink
    int stall_left, hold_left;
    stall_left = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        stall_left = calm ? 0 : int'($urandom_range(0, 3));
      end
      if (hold_req) begin
        hold_left = LongHold;
        hold_req = 1'b0;
      end
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    sensor_frame_t f;
    int p, k, gap;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = RegBaseSpeed;
    cfg_data = '0;
    in_valid = 1'b0;
    {white_left, white_right, outer_left, outer_right, back_left, back_right,
     green_left, green_right, red_left, red_right} = '0;
    frames_sent = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed frames under the reset settings.
    f = '0;
    send_frame(f, draw_gap());
    f = '1;
    send_frame(f, draw_gap());
    f = '0; f.white_left = '1;
    send_frame(f, draw_gap());
    f = '0; f.white_right = '1;
    send_frame(f, draw_gap());
    f = '0; f.outer_left = '1;
    send_frame(f, draw_gap());
    f = '0; f.outer_right = '1;
    send_frame(f, draw_gap());
    f = '0; f.back_left = '1;
    send_frame(f, draw_gap());
    f = '0; f.back_right = '1;
    send_frame(f, draw_gap());
    f = '0; f.green_right = '1; f.red_left = '1;
    send_frame(f, draw_gap());
    // Equal front and rear magnitudes: the rear difference wins the tie.
    f = '0; f.white_left = 12'd1; f.back_left = 12'd2;
    send_frame(f, draw_gap());
    f = '0; f.white_left = 12'd3;
    repeat (3) send_frame(f, draw_gap());
    // Repeated saturated error drives the error sum into its clamp.
    f = '0; f.green_left = '1; f.red_right = '1;
    repeat (5) send_frame(f, draw_gap());
    f = {10{12'haaa}};
    send_frame(f, draw_gap());
    f = {10{12'h555}};
    send_frame(f, draw_gap());
    wait_drained();

    for (p = 0; p < NumPhases; p++) begin
      set_config(pick_setting(p));
      calm = (p % 3 == 2);
      for (k = 0; k < PhaseFrames; k++) begin
        gap = draw_gap();
        if (p == 1 && k == 100) begin
          hold_req = 1'b1;
        end
        if (p == 1 && k >= 100 && k < 140) begin
          gap = 0;
        end
        if (p == 4 && k == 125) begin
          wait_drained();
        end
        send_frame(random_frame(), gap);
      end
      wait_drained();
    end

    repeat (20) @(negedge clk);
    $display("%0d frames sent over %0d register settings, %0d result words checked",
             frames_sent, NumPhases + 1, words_checked);
    $display("deadband zeroed %0d corrections, reverse speed chosen on %0d frames",
             deadband_hits, reverse_hits);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
